[sv/cti_pkg.sv]
// Shared types and constants of the causal third-order recursive filter.
`default_nettype none

package cti_pkg;

   localparam int COEF_BITS    = 18;
   localparam int OUT_BITS     = 32;
   localparam int REG_IDX_BITS = 3;
   localparam int POS_BITS     = 2;

   // position at which the recursion runs; below it the warm-up outputs zero
   localparam logic [POS_BITS-1:0] POS_RUN = 2'd3;

   localparam logic signed [OUT_BITS-1:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = 32'sh8000_0000;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_FF0 = 3'd0,
      REG_FF1 = 3'd1,
      REG_FF2 = 3'd2,
      REG_FB1 = 3'd3,
      REG_FB2 = 3'd4,
      REG_FB3 = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] ff0;
      logic signed [COEF_BITS-1:0] ff1;
      logic signed [COEF_BITS-1:0] ff2;
      logic signed [COEF_BITS-1:0] fb1;
      logic signed [COEF_BITS-1:0] fb2;
      logic signed [COEF_BITS-1:0] fb3;
   } coef_set_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] y1;
      logic signed [OUT_BITS-1:0] y2;
      logic signed [OUT_BITS-1:0] y3;
   } out_hist_type;

endpackage

`default_nettype wire

[sv/causal_third_order_iir_unit.sv]
// Top level of the causal third-order recursive line filter.
// Data path: a req transfer lands in the input register, and the result register loads from
// it when empty or being drained; rsp_tvalid rises with that load.
// Throughput: one item per cycle unless rsp_tready stalls; the loop from the output history
// through six multipliers, the adder and the saturation back into the history is combinational.
// Reset (synchronous): clears the coefficients, line position, histories and both valid flags.
`default_nettype none

module causal_third_order_iir_unit #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input stream
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // [SAMPLE_BITS-1:0] sample
   input  wire logic                                   req_tuser,  // [0] line_start
   // result stream
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [cti_pkg::OUT_BITS-1:0]                rsp_tdata,  // [31:0] filtered
   // coefficient writes
   input  wire logic                                   csr_wr_en,
   input  wire logic [cti_pkg::REG_IDX_BITS-1:0]       csr_index,
   input  wire logic [cti_pkg::COEF_BITS-1:0]          csr_wdata
);

   // ---------------------------------------------------------------
   // Pipeline control: input register feeds the MAC, the result register
   // holds the finished value. The input stage advances whenever the result
   // register is empty or is being drained in the same cycle.
   // ---------------------------------------------------------------
   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   logic signed [SAMPLE_BITS-1:0]        sample_ff;
   logic                                 line_start_ff;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   logic signed [cti_pkg::OUT_BITS-1:0]  out_data_ff;
   logic                                 req_xfer;
   logic                                 advance;

   cti_pkg::coef_set_type                coefs;
   cti_pkg::out_hist_type                y_hist;
   logic signed [SAMPLE_BITS-1:0]        x1;
   logic signed [SAMPLE_BITS-1:0]        x2;
   logic                                 run;
   logic signed [cti_pkg::OUT_BITS-1:0]  y_sat;
   logic signed [cti_pkg::OUT_BITS-1:0]  y_new;

   assign advance     = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;
   assign req_xfer    = req_tvalid & req_tready;
   assign in_valid_in = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   // clear control state on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: capture on a transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff     <= req_tdata[SAMPLE_BITS-1:0];
         line_start_ff <= req_tuser;
      end
      if (advance) begin
         out_data_ff <= y_new;
      end
   end

   // ---------------------------------------------------------------
   // Coefficients, history and arithmetic
   // ---------------------------------------------------------------
   cti_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   cti_history #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_history (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .line_start (line_start_ff),
      .sample     (sample_ff),
      .y_new      (y_new),
      .run        (run),
      .x1         (x1),
      .x2         (x2),
      .y_hist     (y_hist)
   );

   cti_mac #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .coefs  (coefs),
      .x0     (sample_ff),
      .x1     (x1),
      .x2     (x2),
      .y_hist (y_hist),
      .y_sat  (y_sat)
   );

   // warm-up samples of a line output zero and feed zero back
   assign y_new = run ? y_sat : '0;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_tvalid))
      else $error("pipeline not empty after reset");

   // a held input item is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled input item lost");

   // the first sample of a line always yields zero
   a_line_start_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && line_start_ff) |=> (rsp_tvalid && rsp_tdata == '0))
      else $error("line start sample gave a nonzero result");

endmodule

`default_nettype wire

[sv/cti_coef_regs.sv]
// Coefficient register file written through the CSR port.
`default_nettype none

module cti_coef_regs (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [cti_pkg::REG_IDX_BITS-1:0]      csr_index,
   input  wire logic signed [cti_pkg::COEF_BITS-1:0]  csr_wdata,
   output cti_pkg::coef_set_type                      coefs
);

   cti_pkg::coef_set_type coefs_ff;
   cti_pkg::coef_set_type coefs_in;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_wr_en) begin
         case (cti_pkg::reg_idx_type'(csr_index))
            cti_pkg::REG_FF0: coefs_in.ff0 = csr_wdata;
            cti_pkg::REG_FF1: coefs_in.ff1 = csr_wdata;
            cti_pkg::REG_FF2: coefs_in.ff2 = csr_wdata;
            cti_pkg::REG_FB1: coefs_in.fb1 = csr_wdata;
            cti_pkg::REG_FB2: coefs_in.fb2 = csr_wdata;
            cti_pkg::REG_FB3: coefs_in.fb3 = csr_wdata;
            default:          coefs_in = coefs_ff;   // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

`default_nettype wire

[sv/cti_history.sv]
// Line position counter and the input and output history of the recursion.
`default_nettype none

module cti_history #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 advance,
   input  wire logic                                 line_start,
   input  wire logic signed [SAMPLE_BITS-1:0]        sample,
   input  wire logic signed [cti_pkg::OUT_BITS-1:0]  y_new,
   output logic                                      run,
   output logic signed [SAMPLE_BITS-1:0]             x1,
   output logic signed [SAMPLE_BITS-1:0]             x2,
   output cti_pkg::out_hist_type                     y_hist
);

   logic [cti_pkg::POS_BITS-1:0]   position_ff;
   logic [cti_pkg::POS_BITS-1:0]   position_in;
   logic [cti_pkg::POS_BITS-1:0]   pos_live;
   logic signed [SAMPLE_BITS-1:0]  x1_ff;
   logic signed [SAMPLE_BITS-1:0]  x2_ff;
   cti_pkg::out_hist_type          y_hist_ff;

   // a line start clears the position before this sample is judged
   assign pos_live    = line_start ? '0 : position_ff;
   assign run         = (pos_live == cti_pkg::POS_RUN);
   assign position_in = run ? pos_live : cti_pkg::POS_BITS'(pos_live + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         x1_ff       <= '0;
         x2_ff       <= '0;
         y_hist_ff   <= '0;
      end else if (advance) begin
         position_ff  <= position_in;
         x2_ff        <= x1_ff;
         x1_ff        <= sample;
         y_hist_ff.y3 <= y_hist_ff.y2;
         y_hist_ff.y2 <= y_hist_ff.y1;
         y_hist_ff.y1 <= y_new;
      end
   end

   assign x1     = x1_ff;
   assign x2     = x2_ff;
   assign y_hist = y_hist_ff;

endmodule

`default_nettype wire

[sv/cti_mac.sv]
// Six-tap multiply-accumulate with floor shift and 32-bit saturation.
`default_nettype none

module cti_mac #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire cti_pkg::coef_set_type                coefs,
   input  wire logic signed [SAMPLE_BITS-1:0]        x0,
   input  wire logic signed [SAMPLE_BITS-1:0]        x1,
   input  wire logic signed [SAMPLE_BITS-1:0]        x2,
   input  wire cti_pkg::out_hist_type                y_hist,
   output logic signed [cti_pkg::OUT_BITS-1:0]       y_sat
);

   localparam int XP_W  = cti_pkg::COEF_BITS + SAMPLE_BITS;
   localparam int YP_W  = cti_pkg::COEF_BITS + cti_pkg::OUT_BITS;
   localparam int OP_W  = (SAMPLE_BITS > cti_pkg::OUT_BITS) ? SAMPLE_BITS : cti_pkg::OUT_BITS;
   localparam int ACC_W = cti_pkg::COEF_BITS + OP_W + 3;
   localparam int SH_W  = ACC_W - COEF_FRAC_BITS;
   localparam int TOP_W = SH_W - cti_pkg::OUT_BITS + 1;

   logic signed [XP_W-1:0]  p_ff0;
   logic signed [XP_W-1:0]  p_ff1;
   logic signed [XP_W-1:0]  p_ff2;
   logic signed [YP_W-1:0]  p_fb1;
   logic signed [YP_W-1:0]  p_fb2;
   logic signed [YP_W-1:0]  p_fb3;
   logic signed [ACC_W-1:0] acc;
   logic signed [SH_W-1:0]  shifted;
   logic [TOP_W-1:0]        top_bits;
   logic                    in_range;

   assign p_ff0 = coefs.ff0 * x0;
   assign p_ff1 = coefs.ff1 * x1;
   assign p_ff2 = coefs.ff2 * x2;
   assign p_fb1 = coefs.fb1 * y_hist.y1;
   assign p_fb2 = coefs.fb2 * y_hist.y2;
   assign p_fb3 = coefs.fb3 * y_hist.y3;

   assign acc = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2)
              + ACC_W'(p_fb1) + ACC_W'(p_fb2) + ACC_W'(p_fb3);

   // dropping the fraction bits of a two's complement value rounds toward minus infinity
   assign shifted  = acc[ACC_W-1:COEF_FRAC_BITS];
   assign top_bits = shifted[SH_W-1:cti_pkg::OUT_BITS-1];
   assign in_range = (&top_bits) | ~(|top_bits);

   always_comb begin
      if (in_range) begin
         y_sat = shifted[cti_pkg::OUT_BITS-1:0];
      end else if (shifted[SH_W-1]) begin
         y_sat = cti_pkg::OUT_MIN;
      end else begin
         y_sat = cti_pkg::OUT_MAX;
      end
   end

endmodule

`default_nettype wire
